/* rtl/nvrs_pkg.sv */
// Shared types and constants for the NV21 bilinear resize-to-RGB pipeline.
// Used by nvrs_axis, nvrs_rgb and nv21_bilinear_resize_to_rgb; no dependencies.
package nvrs_pkg;

    localparam int OUT_SIZE_DEF    = 640;
    localparam int MAX_SRC_DIM_DEF = 4096;

    localparam int COORD_W = 10;
    localparam int PIX_W   = 8;
    localparam int IDX_W   = 12;
    localparam int CFG_W   = 13;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_W-1:0] SRC_WIDTH_RST  = 13'd640;
    localparam logic [CFG_W-1:0] SRC_HEIGHT_RST = 13'd640;

    localparam int AXIS_LAT  = 5;
    localparam int RGB_LAT   = 4;
    localparam int TOTAL_LAT = AXIS_LAT + RGB_LAT;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SRC_WIDTH  = 1'b0,
        REG_SRC_HEIGHT = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic [PIX_W-1:0] y_top_left;
        logic [PIX_W-1:0] y_top_right;
        logic [PIX_W-1:0] y_bottom_left;
        logic [PIX_W-1:0] y_bottom_right;
        logic [PIX_W-1:0] v_sample;
        logic [PIX_W-1:0] u_sample;
    } t_smp;

    typedef struct packed {
        logic [COORD_W-1:0] out_x;
        logic [COORD_W-1:0] out_y;
        logic [PIX_W-1:0]   y_top_left;
        logic [PIX_W-1:0]   y_top_right;
        logic [PIX_W-1:0]   y_bottom_left;
        logic [PIX_W-1:0]   y_bottom_right;
        logic [PIX_W-1:0]   v_sample;
        logic [PIX_W-1:0]   u_sample;
    } t_pix_in;

    typedef struct packed {
        logic [IDX_W-1:0] src_col0;
        logic [IDX_W-1:0] src_col1;
        logic [IDX_W-1:0] src_row0;
        logic [IDX_W-1:0] src_row1;
        logic [IDX_W-1:0] chroma_col;
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } t_pix_out;

endpackage

/* rtl/nvrs_axis.sv */
// Per-axis coordinate mapper: output coordinate to two source indices and a Q8 weight.
// Five register stages; division by OUT_SIZE is a reciprocal multiply with one correction.
// Depends on nvrs_pkg.
module nvrs_axis #(
    parameter int OUT_SIZE    = nvrs_pkg::OUT_SIZE_DEF,
    parameter int MAX_SRC_DIM = nvrs_pkg::MAX_SRC_DIM_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_vld,
    input  logic [nvrs_pkg::COORD_W-1:0]            i_coord,
    input  logic [$clog2(MAX_SRC_DIM+1)-1:0]        i_size,
    output logic                                    o_vld,
    output logic [$clog2(MAX_SRC_DIM+1)-1:0]        o_i0,
    output logic [$clog2(MAX_SRC_DIM+1)-1:0]        o_i1,
    output logic [7:0]                              o_wt
);

    localparam int SW  = $clog2(MAX_SRC_DIM+1);
    localparam int OW  = nvrs_pkg::COORD_W;
    localparam int NW  = $clog2(OUT_SIZE+1);
    localparam int CMW = (NW > OW) ? NW : OW;
    localparam int PW  = OW + 1 + SW;
    localparam int XW  = PW + 7;
    localparam int FL  = NW - 1;
    localparam int QW  = XW - FL;
    localparam int AW  = QW - 8;
    localparam int CW2 = (AW > SW) ? AW : SW;
    localparam longint unsigned RECIP = (64'd1 << XW) / OUT_SIZE;
    localparam int MW  = $clog2(RECIP + 1);
    localparam int LAT = nvrs_pkg::AXIS_LAT;

    logic [LAT-1:0] r_vld;

    logic [PW-1:0] r1_p;
    logic [SW-1:0] r1_size;
    logic [QW-1:0] r2_q;
    logic [PW-1:0] r2_p;
    logic [SW-1:0] r2_size;
    logic [QW-1:0] r3_q;
    logic [PW-1:0] r3_p;
    logic [XW-1:0] r3_qn;
    logic [SW-1:0] r3_size;
    logic [QW-1:0] r4_num;
    logic [SW-1:0] r4_size;
    logic [SW-1:0] r5_i0;
    logic [SW-1:0] r5_i1;
    logic [7:0]    r5_wt;

    logic [OW-1:0]    oc;
    logic [OW:0]      odd;
    logic [PW-1:0]    n_p;
    logic [PW+MW-1:0] prod;
    logic [QW-1:0]    n_q;
    logic [XW-1:0]    n_qn;
    logic [XW-1:0]    rem;
    logic [QW-1:0]    n_num;
    logic [QW-1:0]    qq;
    logic [AW-1:0]    a_raw;
    logic [SW-1:0]    size_m1;
    logic [SW-1:0]    a_c;
    logic [SW-1:0]    n_i1;

    // Stage 1: saturate coordinate, form (2*o+1)*size
    always_comb begin
        if (CMW'(i_coord) > CMW'(OUT_SIZE - 1)) begin
            oc = OW'(OUT_SIZE - 1);
        end else begin
            oc = i_coord;
        end
        odd = {oc, 1'b1};
        n_p = PW'(odd) * PW'(i_size);
    end

    // Stage 2: reciprocal estimate, low by at most one
    always_comb begin
        prod = (PW+MW)'(r1_p) * (PW+MW)'(RECIP);
        n_q  = QW'(prod >> PW);
    end

    // Stage 3: back-multiply the estimate
    assign n_qn = XW'(r2_q) * XW'(OUT_SIZE);

    // Stage 4: correct by one where the remainder reaches the divisor
    always_comb begin
        rem   = {r3_p, 7'b0} - r3_qn;
        n_num = r3_q + QW'(rem >= XW'(OUT_SIZE));
    end

    // Stage 5: remove the half-pixel offset, split index and weight, clamp at the edge
    always_comb begin
        if (r4_num < QW'(128)) begin
            qq = '0;
        end else begin
            qq = r4_num - QW'(128);
        end
        a_raw   = qq[QW-1:8];
        size_m1 = r4_size - SW'(1);
        if (CW2'(a_raw) > CW2'(size_m1)) begin
            a_c = size_m1;
        end else begin
            a_c = SW'(a_raw);
        end
        if ((SW+1)'(a_c) + (SW+1)'(1) < (SW+1)'(r4_size)) begin
            n_i1 = a_c + SW'(1);
        end else begin
            n_i1 = size_m1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r1_p    <= n_p;
        r1_size <= i_size;
        r2_q    <= n_q;
        r2_p    <= r1_p;
        r2_size <= r1_size;
        r3_q    <= r2_q;
        r3_p    <= r2_p;
        r3_qn   <= n_qn;
        r3_size <= r2_size;
        r4_num  <= n_num;
        r4_size <= r3_size;
        r5_i0   <= a_c;
        r5_i1   <= n_i1;
        r5_wt   <= qq[7:0];
    end

    assign o_vld = r_vld[LAT-1];
    assign o_i0  = r5_i0;
    assign o_i1  = r5_i1;
    assign o_wt  = r5_wt;

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[2] |-> ((XW+1)'(rem) < (XW+1)'(2 * OUT_SIZE)))
        else $error("reciprocal estimate off by more than one");

    a_nbr_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_vld |-> ((o_i1 == o_i0) || ((SW+1)'(o_i1) == (SW+1)'(o_i0) + (SW+1)'(1))))
        else $error("neighbor index not adjacent");

endmodule

/* rtl/nvrs_rgb.sv */
// Bilinear luma interpolation and BT.601 video-range YUV to RGB conversion.
// Four register stages. Depends on nvrs_pkg.
module nvrs_rgb (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_vld,
    input  nvrs_pkg::t_smp              i_smp,
    input  logic [7:0]                  i_wx,
    input  logic [7:0]                  i_wy,
    output logic                        o_vld,
    output logic [nvrs_pkg::PIX_W-1:0]  o_red,
    output logic [nvrs_pkg::PIX_W-1:0]  o_green,
    output logic [nvrs_pkg::PIX_W-1:0]  o_blue
);

    localparam int LAT = nvrs_pkg::RGB_LAT;

    logic [LAT-1:0] r_vld;

    logic [15:0] r1_top;
    logic [15:0] r1_bot;
    logic [7:0]  r1_wy;
    logic [7:0]  r1_v;
    logic [7:0]  r1_u;
    logic [7:0]  r2_lum;
    logic [7:0]  r2_v;
    logic [7:0]  r2_u;
    logic signed [17:0] r3_cc;
    logic signed [17:0] r3_p409;
    logic signed [17:0] r3_p100;
    logic signed [17:0] r3_p208;
    logic signed [17:0] r3_p516;
    logic [7:0]  r4_red;
    logic [7:0]  r4_green;
    logic [7:0]  r4_blue;

    logic [8:0]  inv_x;
    logic [16:0] n_top;
    logic [16:0] n_bot;
    logic [8:0]  inv_y;
    logic [24:0] lum_sum;
    logic signed [9:0]  lm;
    logic signed [8:0]  ev;
    logic signed [8:0]  du;
    logic signed [19:0] t_r;
    logic signed [19:0] t_g;
    logic signed [19:0] t_b;

    function automatic logic [7:0] sat8(input logic signed [19:0] t);
        logic signed [11:0] sh;
        sh = 12'(t >>> 8);
        if (t < 0) begin
            return 8'd0;
        end else if (sh > 12'sd255) begin
            return 8'd255;
        end else begin
            return sh[7:0];
        end
    endfunction

    // Stage 1: horizontal blend of both rows
    always_comb begin
        inv_x = 9'd256 - 9'(i_wx);
        n_top = 17'(i_smp.y_top_left) * 17'(inv_x) + 17'(i_smp.y_top_right) * 17'(i_wx);
        n_bot = 17'(i_smp.y_bottom_left) * 17'(inv_x)
              + 17'(i_smp.y_bottom_right) * 17'(i_wx);
    end

    // Stage 2: vertical blend, round Q16 down to 8 bits
    always_comb begin
        inv_y   = 9'd256 - 9'(r1_wy);
        lum_sum = 25'(r1_top) * 25'(inv_y) + 25'(r1_bot) * 25'(r1_wy) + 25'd32768;
    end

    // Stage 3: scale luma and chroma terms
    always_comb begin
        lm = $signed({2'b00, r2_lum}) - 10'sd16;
        ev = $signed({1'b0, r2_v}) - 9'sd128;
        du = $signed({1'b0, r2_u}) - 9'sd128;
    end

    // Stage 4: sum, shift and saturate each channel
    always_comb begin
        t_r = 20'(r3_cc) + 20'(r3_p409) + 20'sd128;
        t_g = 20'(r3_cc) - 20'(r3_p100) - 20'(r3_p208) + 20'sd128;
        t_b = 20'(r3_cc) + 20'(r3_p516) + 20'sd128;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r1_top   <= n_top[15:0];
        r1_bot   <= n_bot[15:0];
        r1_wy    <= i_wy;
        r1_v     <= i_smp.v_sample;
        r1_u     <= i_smp.u_sample;
        r2_lum   <= lum_sum[23:16];
        r2_v     <= r1_v;
        r2_u     <= r1_u;
        r3_cc    <= 18'(lm) * 18'sd298;
        r3_p409  <= 18'(ev) * 18'sd409;
        r3_p100  <= 18'(du) * 18'sd100;
        r3_p208  <= 18'(ev) * 18'sd208;
        r3_p516  <= 18'(du) * 18'sd516;
        r4_red   <= sat8(t_r);
        r4_green <= sat8(t_g);
        r4_blue  <= sat8(t_b);
    end

    assign o_vld   = r_vld[LAT-1];
    assign o_red   = r4_red;
    assign o_green = r4_green;
    assign o_blue  = r4_blue;

endmodule

/* rtl/nv21_bilinear_resize_to_rgb.sv */
// NV21 bilinear resize to RGB, top level: config registers, axis mappers, color pipeline.
// Depends on nvrs_pkg, nvrs_axis and nvrs_rgb.
//
//   Channel   Direction  Handshake                     Beat
//   pixel in  in         start & !busy                 t_pix_in (coordinate + samples)
//   result    out        o_res_vld, one-cycle strobe   t_pix_out (fetch coords + RGB)
//   config    in         i_cfg_valid & o_cfg_ready     i_cfg_index, i_cfg_data
//
// One beat is taken every cycle; busy stays low.
// Data passes through the axis mappers (multiply, reciprocal multiply, back-multiply,
// correction, split), then through the interpolate/convert path.
// The receiver cannot stall, so the pipeline runs free; the valid bits ride with the data.
// Synchronous reset clears the valid bits and sets both sizes to 640.
module nv21_bilinear_resize_to_rgb #(
    parameter int OUT_SIZE    = nvrs_pkg::OUT_SIZE_DEF,
    parameter int MAX_SRC_DIM = nvrs_pkg::MAX_SRC_DIM_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  nvrs_pkg::t_pix_in                   i_pix,
    output logic                                o_res_vld,
    output nvrs_pkg::t_pix_out                  o_res,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [nvrs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [nvrs_pkg::CFG_W-1:0]          i_cfg_data
);

    localparam int SW   = $clog2(MAX_SRC_DIM+1);
    localparam int CW   = nvrs_pkg::CFG_W;
    localparam int EW   = (SW > CW) ? SW : CW;
    localparam int IW   = nvrs_pkg::IDX_W;
    localparam int ALAT = nvrs_pkg::AXIS_LAT;
    localparam int RLAT = nvrs_pkg::RGB_LAT;

    typedef struct packed {
        logic [IW-1:0] col0;
        logic [IW-1:0] col1;
        logic [IW-1:0] row0;
        logic [IW-1:0] row1;
    } t_crd;

    logic [CW-1:0] r_src_width;
    logic [CW-1:0] r_src_height;

    nvrs_pkg::t_smp r_smp [ALAT];
    t_crd           r_crd [RLAT];

    logic           accept;
    logic [SW-1:0]  eff_w;
    logic [SW-1:0]  eff_h;
    nvrs_pkg::t_smp smp_in;
    logic           vld_x;
    logic           vld_y;
    logic [SW-1:0]  col0;
    logic [SW-1:0]  col1;
    logic [SW-1:0]  row0;
    logic [SW-1:0]  row1;
    logic [7:0]     wx;
    logic [7:0]     wy;
    t_crd           n_crd;
    logic           rgb_vld;
    logic [7:0]     red;
    logic [7:0]     green;
    logic [7:0]     blue;

    function automatic logic [SW-1:0] eff_size(input logic [CW-1:0] v);
        if (v == '0) begin
            return SW'(1);
        end else if (EW'(v) > EW'(MAX_SRC_DIM)) begin
            return SW'(MAX_SRC_DIM);
        end else begin
            return SW'(v);
        end
    endfunction

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;
    assign eff_w       = eff_size(r_src_width);
    assign eff_h       = eff_size(r_src_height);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width  <= nvrs_pkg::SRC_WIDTH_RST;
            r_src_height <= nvrs_pkg::SRC_HEIGHT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (nvrs_pkg::t_cfg_reg'(i_cfg_index))
                nvrs_pkg::REG_SRC_WIDTH: begin
                    r_src_width <= i_cfg_data;
                end
                nvrs_pkg::REG_SRC_HEIGHT: begin
                    r_src_height <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    nvrs_axis #(
        .OUT_SIZE    (OUT_SIZE),
        .MAX_SRC_DIM (MAX_SRC_DIM)
    ) u_axis_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (accept),
        .i_coord (i_pix.out_x),
        .i_size  (eff_w),
        .o_vld   (vld_x),
        .o_i0    (col0),
        .o_i1    (col1),
        .o_wt    (wx)
    );

    nvrs_axis #(
        .OUT_SIZE    (OUT_SIZE),
        .MAX_SRC_DIM (MAX_SRC_DIM)
    ) u_axis_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (accept),
        .i_coord (i_pix.out_y),
        .i_size  (eff_h),
        .o_vld   (vld_y),
        .o_i0    (row0),
        .o_i1    (row1),
        .o_wt    (wy)
    );

    always_comb begin
        smp_in.y_top_left     = i_pix.y_top_left;
        smp_in.y_top_right    = i_pix.y_top_right;
        smp_in.y_bottom_left  = i_pix.y_bottom_left;
        smp_in.y_bottom_right = i_pix.y_bottom_right;
        smp_in.v_sample       = i_pix.v_sample;
        smp_in.u_sample       = i_pix.u_sample;
        n_crd.col0 = IW'(col0);
        n_crd.col1 = IW'(col1);
        n_crd.row0 = IW'(row0);
        n_crd.row1 = IW'(row1);
    end

    // Hold samples until the weights come out of the mappers, coords until RGB is ready
    always_ff @(posedge i_clk) begin
        r_smp[0] <= smp_in;
        for (int k = 1; k < ALAT; k++) begin
            r_smp[k] <= r_smp[k-1];
        end
        r_crd[0] <= n_crd;
        for (int k = 1; k < RLAT; k++) begin
            r_crd[k] <= r_crd[k-1];
        end
    end

    nvrs_rgb u_rgb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (vld_x && vld_y),
        .i_smp   (r_smp[ALAT-1]),
        .i_wx    (wx),
        .i_wy    (wy),
        .o_vld   (rgb_vld),
        .o_red   (red),
        .o_green (green),
        .o_blue  (blue)
    );

    always_comb begin
        o_res.src_col0   = r_crd[RLAT-1].col0;
        o_res.src_col1   = r_crd[RLAT-1].col1;
        o_res.src_row0   = r_crd[RLAT-1].row0;
        o_res.src_row1   = r_crd[RLAT-1].row1;
        o_res.chroma_col = {r_crd[RLAT-1].col0[IW-1:1], 1'b0};
        o_res.red        = red;
        o_res.green      = green;
        o_res.blue       = blue;
    end

    assign o_res_vld = rgb_vld;

    a_beat_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##(nvrs_pkg::TOTAL_LAT) o_res_vld)
        else $error("accepted beat produced no result");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_vld |-> $past(accept, nvrs_pkg::TOTAL_LAT))
        else $error("result without a matching input beat");

    a_axes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        vld_x == vld_y)
        else $error("axis mappers out of step");

endmodule

/* bench/rgb_pixel_checker.sv */
// Watches the pixel, result and register channels of nv21_bilinear_resize_to_rgb,
// predicts each output pixel and compares it field by field.
// Depends on nvrs_pkg for the beat types and size constants.
module rgb_pixel_checker
    import nvrs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_busy,
    input  t_pix_in              i_pix,
    input  logic                 i_res_vld,
    input  t_pix_out             i_res,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output int                   o_mismatch_count,
    output int                   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [CFG_W-1:0] width_reg  = SRC_WIDTH_RST;
    logic [CFG_W-1:0] height_reg = SRC_HEIGHT_RST;
    t_pix_out         pending_pixels[$];

    function automatic int unsigned clip_size(logic [CFG_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_SRC_DIM_DEF) return MAX_SRC_DIM_DEF;
        return v;
    endfunction

    // Q8 source position: integer part picks the first index, low byte is the weight.
    function automatic void map_coord(input logic [COORD_W-1:0] o, input int unsigned size,
                                      output logic [IDX_W-1:0] first,
                                      output logic [IDX_W-1:0] second,
                                      output int unsigned frac);
        longint unsigned oc;
        longint unsigned num;
        longint unsigned q;
        longint unsigned a;
        oc = (o > OUT_SIZE_DEF - 1) ? OUT_SIZE_DEF - 1 : o;
        num = ((2 * oc + 1) * size * 128) / OUT_SIZE_DEF;
        q = (num < 128) ? 0 : num - 128;
        a = q >> 8;
        if (a > size - 1) a = size - 1;
        first = a[IDX_W-1:0];
        second = (a + 1 < size) ? IDX_W'(a + 1) : IDX_W'(size - 1);
        frac = 32'(q & 255);
    endfunction

    function automatic logic [PIX_W-1:0] sat_channel(int sum);
        int r;
        if (sum < 0) return '0;
        r = sum >>> 8;
        return (r > 255) ? 8'd255 : r[PIX_W-1:0];
    endfunction

    function automatic t_pix_out predict_pixel(t_pix_in p, logic [CFG_W-1:0] w_reg,
                                               logic [CFG_W-1:0] h_reg);
        t_pix_out    res;
        logic [IDX_W-1:0] c0, c1, r0, r1;
        int unsigned wx, wy, top, bot, lum;
        int          luma_term, v_off, u_off;
        map_coord(p.out_x, clip_size(w_reg), c0, c1, wx);
        map_coord(p.out_y, clip_size(h_reg), r0, r1, wy);
        top = p.y_top_left * (256 - wx) + p.y_top_right * wx;
        bot = p.y_bottom_left * (256 - wx) + p.y_bottom_right * wx;
        lum = (top * (256 - wy) + bot * wy + 32768) >> 16;
        luma_term = 298 * (int'(lum) - 16);
        v_off = int'(p.v_sample) - 128;
        u_off = int'(p.u_sample) - 128;
        res.src_col0   = c0;
        res.src_col1   = c1;
        res.src_row0   = r0;
        res.src_row1   = r1;
        res.chroma_col = {c0[IDX_W-1:1], 1'b0};
        res.red   = sat_channel(luma_term + 409 * v_off + 128);
        res.green = sat_channel(luma_term - 100 * u_off - 208 * v_off + 128);
        res.blue  = sat_channel(luma_term + 516 * u_off + 128);
        return res;
    endfunction

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            o_mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_pix_out want;
        if (!i_rst_n) begin
            width_reg  = SRC_WIDTH_RST;
            height_reg = SRC_HEIGHT_RST;
            pending_pixels.delete();
        end else begin
            if (i_res_vld) begin
                if (pending_pixels.size() == 0) begin
                    $error("result beat with no pixel outstanding");
                    o_mismatch_count++;
                end else begin
                    want = pending_pixels.pop_front();
                    check_field("src_col0", want.src_col0, i_res.src_col0);
                    check_field("src_col1", want.src_col1, i_res.src_col1);
                    check_field("src_row0", want.src_row0, i_res.src_row0);
                    check_field("src_row1", want.src_row1, i_res.src_row1);
                    check_field("chroma_col", want.chroma_col, i_res.chroma_col);
                    check_field("red", want.red, i_res.red);
                    check_field("green", want.green, i_res.green);
                    check_field("blue", want.blue, i_res.blue);
                end
            end
            // Predict with the sizes in force before any write at this edge.
            if (i_start && !i_busy)
                pending_pixels.push_back(predict_pixel(i_pix, width_reg, height_reg));
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == REG_SRC_WIDTH) width_reg = i_cfg_data;
                else if (i_cfg_index == REG_SRC_HEIGHT) height_reg = i_cfg_data;
            end
        end
        o_pending = pending_pixels.size();
    end

endmodule

/* bench/tb.sv */
// Regression top for nv21_bilinear_resize_to_rgb: clock, reset, pixel and register stimulus.
// Depends on nvrs_pkg, the block itself and rgb_pixel_checker.
module tb;
    import nvrs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 150;

    logic             clk;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    t_pix_in          pix = '0;
    logic             res_vld;
    t_pix_out         res;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    t_cfg_reg         cfg_index = REG_SRC_WIDTH;
    logic [CFG_W-1:0] cfg_data = '0;
    int               mismatches;
    int               pending;
    int               cycles = 0;

    nv21_bilinear_resize_to_rgb u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .start       (start),
        .busy        (busy),
        .i_pix       (pix),
        .o_res_vld   (res_vld),
        .o_res       (res),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    rgb_pixel_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_start          (start),
        .i_busy           (busy),
        .i_pix            (pix),
        .i_res_vld        (res_vld),
        .i_res            (res),
        .i_cfg_valid      (cfg_valid),
        .i_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .o_mismatch_count (mismatches),
        .o_pending        (pending)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("nv21_bilinear_resize_to_rgb regression: fail");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_pix(t_pix_in p);
        start = 1'b1;
        pix = p;
        do @(posedge clk); while (busy);
        @(negedge clk);
    endtask

    task automatic write_reg(t_cfg_reg idx, logic [CFG_W-1:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Hold off until every outstanding pixel is back, then let the pipe empty.
    task automatic drain();
        start = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (TOTAL_LAT) @(negedge clk);
    endtask

    task automatic set_sizes(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
        drain();
        write_reg(REG_SRC_WIDTH, w);
        write_reg(REG_SRC_HEIGHT, h);
    endtask

    function automatic t_pix_in make_pix(int x, int y, int tl, int tr, int bl, int br,
                                         int v, int u);
        t_pix_in p;
        p.out_x = COORD_W'(x);
        p.out_y = COORD_W'(y);
        p.y_top_left = PIX_W'(tl);
        p.y_top_right = PIX_W'(tr);
        p.y_bottom_left = PIX_W'(bl);
        p.y_bottom_right = PIX_W'(br);
        p.v_sample = PIX_W'(v);
        p.u_sample = PIX_W'(u);
        return p;
    endfunction

    function automatic int rand_coord();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return OUT_SIZE_DEF - 1;
            2: return $urandom_range(OUT_SIZE_DEF, 1023);
            default: return $urandom_range(0, OUT_SIZE_DEF - 1);
        endcase
    endfunction

    function automatic int rand_sample();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return 255;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_size();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return CFG_W'(1);
            2: return CFG_W'(MAX_SRC_DIM_DEF);
            3: return CFG_W'($urandom_range(MAX_SRC_DIM_DEF + 1, 8191));
            4: return CFG_W'($urandom_range(2, 16));
            5: return CFG_W'(640);
            default: return CFG_W'($urandom_range(1, MAX_SRC_DIM_DEF));
        endcase
    endfunction

    initial begin
        int burst_left;
        int gap;
        burst_left = 0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset sizes: clamp extremes, coordinate saturation, neutral gray.
        send_pix(make_pix(0, 0, 0, 0, 0, 0, 0, 0));
        send_pix(make_pix(639, 639, 255, 255, 255, 255, 255, 255));
        send_pix(make_pix(640, 1023, 16, 235, 100, 200, 90, 240));
        send_pix(make_pix(1023, 0, 255, 0, 0, 255, 0, 255));
        send_pix(make_pix(320, 321, 128, 128, 128, 128, 128, 128));
        send_pix(make_pix(1, 638, 0, 255, 255, 0, 255, 0));
        send_pix(make_pix(5, 7, 16, 16, 16, 16, 128, 128));
        send_pix(make_pix(511, 512, 170, 85, 85, 170, 255, 0));

        // Zero width acts as one, oversize height acts as the maximum.
        set_sizes(13'd0, 13'd8191);
        send_pix(make_pix(0, 0, 10, 20, 30, 40, 50, 60));
        send_pix(make_pix(639, 639, 200, 100, 50, 25, 128, 200));
        send_pix(make_pix(1023, 1023, 255, 255, 0, 0, 60, 160));

        set_sizes(CFG_W'(MAX_SRC_DIM_DEF), 13'd1);
        send_pix(make_pix(0, 639, 1, 2, 3, 4, 5, 6));
        send_pix(make_pix(639, 0, 250, 251, 252, 253, 254, 255));
        send_pix(make_pix(333, 444, 77, 88, 99, 111, 122, 133));

        set_sizes(13'd8191, 13'd0);
        send_pix(make_pix(639, 639, 255, 0, 255, 0, 200, 50));
        send_pix(make_pix(0, 0, 0, 255, 0, 255, 50, 200));

        // Tiny frame: the right and lower neighbors clamp at the edge.
        set_sizes(13'd2, 13'd3);
        send_pix(make_pix(0, 0, 40, 220, 90, 10, 128, 128));
        send_pix(make_pix(639, 639, 40, 220, 90, 10, 128, 128));
        send_pix(make_pix(320, 213, 255, 0, 0, 255, 140, 110));

        set_sizes(CFG_W'(MAX_SRC_DIM_DEF), CFG_W'(MAX_SRC_DIM_DEF));
        send_pix(make_pix(639, 639, 9, 99, 199, 249, 30, 230));
        send_pix(make_pix(0, 1, 123, 45, 67, 89, 210, 20));

        for (int ph = 0; ph < PHASES; ph++) begin
            set_sizes(pick_size(), pick_size());
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (i == PHASE_ITEMS / 2) drain();
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
                    if (gap != 0) begin
                        start = 1'b0;
                        repeat (gap) @(negedge clk);
                    end
                end
                send_pix(make_pix(rand_coord(), rand_coord(), rand_sample(), rand_sample(),
                                  rand_sample(), rand_sample(), rand_sample(),
                                  rand_sample()));
                burst_left--;
            end
        end

        drain();
        if (mismatches == 0) begin
            $display("nv21_bilinear_resize_to_rgb regression: pass");
        end else begin
            $display("nv21_bilinear_resize_to_rgb regression: fail");
        end
        $finish;
    end

endmodule
